/* src/wbr_pkg.sv */
// Shared types and constants for the windowed byte RAM.
package wbr_pkg;

  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned NUM_BANKS = 4;
  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_TDATA_W = 40;

  typedef enum logic {
    REQ_READ  = 1'b0,
    REQ_WRITE = 1'b1
  } req_type_e;

  typedef enum logic [1:0] {
    SIZE_BYTE  = 2'd0,
    SIZE_HALF  = 2'd1,
    SIZE_DWORD = 2'd2
  } access_size_e;

  // Per-access lane routing: which bank takes part and which data lane it serves
  typedef struct packed {
    logic                      hit;
    logic                      is_write;
    logic [NUM_BANKS-1:0]      bank_en;
    logic [NUM_BANKS-1:0][1:0] bank_lane;
  } wbr_map_t;

endpackage

/* src/wbr_ram.sv */
// Generic single-port RAM with registered read data.
module wbr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/wbr_lane_map.sv */
// Window check and byte-lane to bank routing for one access.
module wbr_lane_map #(
  parameter int unsigned MEM_BYTES = 256,
  parameter int unsigned RW        = 6
) (
  input  logic [wbr_pkg::ADDR_W-1:0]                   base_i,
  input  wbr_pkg::req_type_e                           req_i,
  input  logic [1:0]                                   size_i,
  input  logic [wbr_pkg::ADDR_W-1:0]                   addr_i,
  input  logic [wbr_pkg::DATA_W-1:0]                   wdata_i,
  output wbr_pkg::wbr_map_t                            map_o,
  output logic [wbr_pkg::NUM_BANKS-1:0][RW-1:0]        rows_o,
  output logic [wbr_pkg::NUM_BANKS-1:0][7:0]           wbyte_o
);

  localparam int unsigned OW = $clog2(MEM_BYTES);
  localparam int unsigned PW = $clog2(MEM_BYTES + 3);

  always_comb begin
    logic [wbr_pkg::ADDR_W:0] diff;
    logic [OW-1:0]            off;
    logic [1:0]               k;
    logic [PW-1:0]            pos;
    logic [2:0]               lanes;
    logic                     hit;

    case (wbr_pkg::access_size_e'(size_i))
      wbr_pkg::SIZE_BYTE:  lanes = 3'd1;
      wbr_pkg::SIZE_HALF:  lanes = 3'd2;
      wbr_pkg::SIZE_DWORD: lanes = 3'd4;
      default:             lanes = 3'd0;
    endcase

    // borrow out means the address lies below the base
    diff = {1'b0, addr_i} - {1'b0, base_i};
    hit  = (lanes != 3'd0) && !diff[wbr_pkg::ADDR_W]
           && (diff[wbr_pkg::ADDR_W-1:0] < wbr_pkg::ADDR_W'(MEM_BYTES));
    off  = diff[OW-1:0];

    map_o.hit      = hit;
    map_o.is_write = (req_i == wbr_pkg::REQ_WRITE);

    for (int b = 0; b < wbr_pkg::NUM_BANKS; b++) begin
      // bank b holds bytes whose position is b modulo four
      k   = 2'(b) - off[1:0];
      pos = PW'(off) + PW'(k);
      map_o.bank_lane[b] = k;
      map_o.bank_en[b]   = hit && ({1'b0, k} < lanes) && (pos < PW'(MEM_BYTES));
      rows_o[b]          = RW'(pos >> 2);
      wbyte_o[b]         = wdata_i[8*k +: 8];
    end
  end

endmodule

/* src/windowed_byte_ram_multi_width_top.sv */
// Top level of the windowed byte RAM: stream front end, bank pipeline and read gather.
//
// A byte RAM of MEM_BYTES bytes mapped at base_address on a 32-bit bus. Each
// input word is a read or write of 1, 2 or 4 bytes, little-endian; accesses
// outside the window are ignored and read as 0, and lanes past the last byte
// are dropped. One access is taken every cycle while the result side is not
// stalled, and its result passes through the input register and then the
// registered read of the byte store. The store is split into four byte-lane
// RAM banks so any access, aligned or not, uses each bank at most once. After
// reset the store is cleared one row of four bytes per cycle, during which the
// input is not ready; the base register can be written at any time the block
// is idle.
module windowed_byte_ram_multi_width_top #(
  parameter int unsigned MEM_BYTES = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [wbr_pkg::ADDR_W-1:0]          cfg_data_i,   // base_address
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // [0] req_type, [2:1] access_size, [34:3] bus_address, [66:35] write_data
  input  logic [wbr_pkg::IN_TDATA_W-1:0]      s_axis_tdata_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // [31:0] read_data, [32] dirty_flag
  output logic [wbr_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o
);

  localparam int unsigned ROWS = (MEM_BYTES + 3) / 4;
  localparam int unsigned RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned NB   = wbr_pkg::NUM_BANKS;

  logic [wbr_pkg::ADDR_W-1:0] base_q;

  logic                       v1_q, v1_d;
  wbr_pkg::req_type_e         req1_q;
  logic [1:0]                 size1_q;
  logic [wbr_pkg::ADDR_W-1:0] addr1_q;
  logic [wbr_pkg::DATA_W-1:0] wdata1_q;

  logic                       v2_q, v2_d;
  logic [NB-1:0]              ren2_q;
  logic [NB-1:0][1:0]         lane2_q;
  logic                       dirty2_q;
  logic                       dirty_q, dirty_d;

  logic                       clr_q, clr_d;
  logic [RW-1:0]              clr_row_q, clr_row_d;

  wbr_pkg::wbr_map_t          map;
  logic [NB-1:0][RW-1:0]      rows;
  logic [NB-1:0][7:0]         wbyte;
  logic [NB-1:0]              bank_we, bank_re;
  logic [NB-1:0][RW-1:0]      bank_addr;
  logic [NB-1:0][7:0]         bank_wdata, bank_rdata;

  logic                       s_accept, adv, issue;
  logic [wbr_pkg::DATA_W-1:0] rdata;

  assign cfg_ready_o     = 1'b1;
  assign adv             = !v2_q || m_axis_tready_i;
  assign s_axis_tready_o = !clr_q && (!v1_q || adv);
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;
  assign issue           = v1_q && adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
    end else if (cfg_valid_i) begin
      base_q <= cfg_data_i;
    end
  end

  // clearing sweep after reset
  always_comb begin
    clr_d     = clr_q;
    clr_row_d = clr_row_q;
    if (clr_q) begin
      if (clr_row_q == RW'(ROWS - 1)) begin
        clr_d = 1'b0;
      end else begin
        clr_row_d = clr_row_q + RW'(1);
      end
    end
  end

  always_comb begin
    v1_d = v1_q;
    if (s_accept) begin
      v1_d = 1'b1;
    end else if (adv) begin
      v1_d = 1'b0;
    end
    v2_d    = adv ? v1_q : v2_q;
    dirty_d = dirty_q | (issue && map.hit && map.is_write);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      dirty_q   <= 1'b0;
      clr_q     <= 1'b1;
      clr_row_q <= '0;
    end else begin
      v1_q      <= v1_d;
      v2_q      <= v2_d;
      dirty_q   <= dirty_d;
      clr_q     <= clr_d;
      clr_row_q <= clr_row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      req1_q   <= wbr_pkg::req_type_e'(s_axis_tdata_i[0]);
      size1_q  <= s_axis_tdata_i[2:1];
      addr1_q  <= s_axis_tdata_i[34:3];
      wdata1_q <= s_axis_tdata_i[66:35];
    end
    if (issue) begin
      ren2_q   <= bank_re;
      lane2_q  <= map.bank_lane;
      dirty2_q <= dirty_d;
    end
  end

  wbr_lane_map #(
    .MEM_BYTES (MEM_BYTES),
    .RW        (RW)
  ) u_lane_map (
    .base_i  (base_q),
    .req_i   (req1_q),
    .size_i  (size1_q),
    .addr_i  (addr1_q),
    .wdata_i (wdata1_q),
    .map_o   (map),
    .rows_o  (rows),
    .wbyte_o (wbyte)
  );

  always_comb begin
    for (int b = 0; b < NB; b++) begin
      bank_we[b]    = clr_q || (issue && map.is_write && map.bank_en[b]);
      bank_re[b]    = issue && !map.is_write && map.bank_en[b];
      bank_addr[b]  = clr_q ? clr_row_q : rows[b];
      bank_wdata[b] = clr_q ? 8'h00 : wbyte[b];
    end
  end

  for (genvar g = 0; g < NB; g++) begin : g_bank
    wbr_ram #(
      .WIDTH (8),
      .DEPTH (ROWS)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (bank_we[g]),
      .re_i    (bank_re[g]),
      .addr_i  (bank_addr[g]),
      .wdata_i (bank_wdata[g]),
      .rdata_o (bank_rdata[g])
    );
  end

  // place each bank's byte into the lane it served; unused lanes read 0
  always_comb begin
    rdata = '0;
    for (int k = 0; k < NB; k++) begin
      for (int b = 0; b < NB; b++) begin
        if (ren2_q[b] && (lane2_q[b] == 2'(k))) begin
          rdata[8*k +: 8] = rdata[8*k +: 8] | bank_rdata[b];
        end
      end
    end
  end

  assign m_axis_tvalid_o = v2_q;
  assign m_axis_tdata_o  = {7'b0, dirty2_q, rdata};

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !s_axis_tready_o)
    else $error("input accepted during clearing sweep");

  a_no_item_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !v1_q && !v2_q)
    else $error("access in flight during clearing sweep");

  a_dirty_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dirty_q |=> dirty_q)
    else $error("dirty mark dropped");

  a_bank_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!clr_q && !issue) |-> (bank_we == '0) && (bank_re == '0))
    else $error("bank access without an issued word");

  a_miss_no_bank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && !map.hit) |-> (map.bank_en == '0))
    else $error("bank enabled for an access outside the window");

endmodule

/* tb/sv/wbr_access_checker.sv */
// Access checker for the windowed byte RAM: mirrors the store, predicts each result and compares.
module wbr_access_checker #(
  parameter int unsigned MEM_BYTES = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [wbr_pkg::ADDR_W-1:0]      cfg_data_i,
  input  logic                            s_tvalid_i,
  input  logic                            s_tready_i,
  // [0] req_type, [2:1] access_size, [34:3] bus_address, [66:35] write_data
  input  logic [wbr_pkg::IN_TDATA_W-1:0]  s_tdata_i,
  input  logic                            m_tvalid_i,
  input  logic                            m_tready_i,
  // [31:0] read_data, [32] dirty_flag
  input  logic [wbr_pkg::OUT_TDATA_W-1:0] m_tdata_i,
  output int unsigned                     fail_count_o,
  output int unsigned                     pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [wbr_pkg::DATA_W-1:0] read_data;
    logic                       dirty_flag;
  } access_result_t;

  logic [7:0]                 mirror_bytes [MEM_BYTES];
  logic                       mirror_dirty;
  logic [wbr_pkg::ADDR_W-1:0] window_base;
  access_result_t             result_q [$];

  // Apply one access to the mirror and return the word the block must answer with
  function automatic access_result_t predict_access(input logic rq, input logic [1:0] sz,
                                                    input logic [wbr_pkg::ADDR_W-1:0] addr,
                                                    input logic [wbr_pkg::DATA_W-1:0] wd);
    access_result_t             res;
    int unsigned                lanes;
    int unsigned                pos;
    logic [wbr_pkg::ADDR_W-1:0] offs;
    res = '0;
    case (sz)
      wbr_pkg::SIZE_BYTE:  lanes = 1;
      wbr_pkg::SIZE_HALF:  lanes = 2;
      wbr_pkg::SIZE_DWORD: lanes = 4;
      default:             lanes = 0;
    endcase
    offs = addr - window_base;
    // no wrap past the top of the address space
    if (lanes != 0 && addr >= window_base && offs < MEM_BYTES) begin
      for (int k = 0; k < lanes; k++) begin
        pos = offs + k;
        if (pos < MEM_BYTES) begin
          if (rq == wbr_pkg::REQ_WRITE) begin
            mirror_bytes[pos] = wd[8*k +: 8];
          end else begin
            res.read_data[8*k +: 8] = mirror_bytes[pos];
          end
        end
      end
      if (rq == wbr_pkg::REQ_WRITE) begin
        mirror_dirty = 1'b1;
      end
    end
    res.dirty_flag = mirror_dirty;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    access_result_t             want;
    logic [wbr_pkg::DATA_W-1:0] got_data;
    logic                       got_dirty;
    if (!rst_ni) begin
      foreach (mirror_bytes[i]) mirror_bytes[i] = '0;
      mirror_dirty = 1'b0;
      window_base  = '0;
      result_q.delete();
      fail_count_o = 0;
      pending_o <= 0;
    end else begin
      // retire the oldest result first: a result never leaves in the same cycle as its access is taken
      if (m_tvalid_i && m_tready_i) begin
        got_data  = m_tdata_i[31:0];
        got_dirty = m_tdata_i[32];
        if (result_q.size() == 0) begin
          $error("result word with no access outstanding: %h", m_tdata_i);
          fail_count_o++;
        end else begin
          want = result_q.pop_front();
          if (got_data !== want.read_data) begin
            $error("read_data: expected %h, got %h", want.read_data, got_data);
            fail_count_o++;
          end
          if (got_dirty !== want.dirty_flag) begin
            $error("dirty_flag: expected %b, got %b", want.dirty_flag, got_dirty);
            fail_count_o++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        result_q.push_back(predict_access(s_tdata_i[0], s_tdata_i[2:1], s_tdata_i[34:3],
                                          s_tdata_i[66:35]));
      end
      if (cfg_valid_i && cfg_ready_i) begin
        window_base = cfg_data_i;
      end
      pending_o <= result_q.size();
    end
  end

endmodule

/* tb/sv/tb_top.sv */
// Testbench top for the windowed byte RAM: clock, reset, access stimulus and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MEM_BYTES     = 256;
  localparam int unsigned QUIET_LIMIT   = 4000;
  localparam int unsigned CHUNK_ACCESSES = 150;
  localparam logic [1:0]  SIZE_UNUSED   = 2'd3;

  logic                            clk_i;
  logic                            rst_ni = 1'b0;
  logic                            cfg_valid_i = 1'b0;
  logic                            cfg_ready_o;
  logic [wbr_pkg::ADDR_W-1:0]      cfg_data_i = '0;
  logic                            s_axis_tvalid_i = 1'b0;
  logic                            s_axis_tready_o;
  logic [wbr_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i = '0;
  logic                            m_axis_tvalid_o;
  logic                            m_axis_tready_i = 1'b0;
  logic [wbr_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned src_gap_pct = 10;
  int unsigned snk_stall_pct = 84;
  int unsigned quiet_cycles = 0;

  windowed_byte_ram_multi_width_top #(
    .MEM_BYTES(MEM_BYTES)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  wbr_access_checker #(
    .MEM_BYTES(MEM_BYTES)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .s_tvalid_i  (s_axis_tvalid_i),
    .s_tready_i  (s_axis_tready_o),
    .s_tdata_i   (s_axis_tdata_i),
    .m_tvalid_i  (m_axis_tvalid_o),
    .m_tready_i  (m_axis_tready_i),
    .m_tdata_i   (m_axis_tdata_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Result side back-pressure
  always @(posedge clk_i) begin
    m_axis_tready_i <= (snk_stall_pct == 0) || ($urandom_range(0, 99) >= snk_stall_pct);
  end

  // Give up when no word moves on any channel for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic issue_access(input wbr_pkg::req_type_e rq, input logic [1:0] sz,
                              input logic [wbr_pkg::ADDR_W-1:0] addr,
                              input logic [wbr_pkg::DATA_W-1:0] wd);
    while (src_gap_pct != 0 && $urandom_range(0, 99) < src_gap_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {5'b0, wd, addr, sz, rq};
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  // Drop valid and hold until every outstanding result has come back
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_base(input logic [wbr_pkg::ADDR_W-1:0] base);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= base;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly hits, with the window tail, its neighbours and stray addresses mixed in
  function automatic logic [wbr_pkg::ADDR_W-1:0] pick_address(
    input logic [wbr_pkg::ADDR_W-1:0] base);
    int unsigned sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1, 2, 3, 4, 5: return base + $urandom_range(0, MEM_BYTES - 1);
      6:                return base + $urandom_range(MEM_BYTES - 4, MEM_BYTES - 1);
      7:                return base - $urandom_range(1, 4);
      8:                return base + $urandom_range(MEM_BYTES, MEM_BYTES + 3);
      default:          return $urandom;
    endcase
  endfunction

  initial begin
    logic [wbr_pkg::ADDR_W-1:0] chunk_base [6];
    wbr_pkg::req_type_e         rq;
    logic [1:0]                 sz;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Window at zero after reset
    issue_access(wbr_pkg::REQ_READ,  wbr_pkg::SIZE_DWORD, 32'h0000_0000, 32'h0);
    issue_access(wbr_pkg::REQ_WRITE, SIZE_UNUSED,         32'h0000_0000, 32'hFFFF_FFFF);
    issue_access(wbr_pkg::REQ_WRITE, wbr_pkg::SIZE_BYTE,  32'h0000_0100, 32'hFFFF_FFFF);
    issue_access(wbr_pkg::REQ_READ,  SIZE_UNUSED,         32'h0000_0000, 32'h0);
    issue_access(wbr_pkg::REQ_WRITE, wbr_pkg::SIZE_BYTE,  32'h0000_0000, 32'h1234_56A5);
    issue_access(wbr_pkg::REQ_WRITE, wbr_pkg::SIZE_HALF,  32'h0000_00FE, 32'hDEAD_BEEF);
    issue_access(wbr_pkg::REQ_WRITE, wbr_pkg::SIZE_DWORD, 32'h0000_00FD, 32'h1122_3344);
    issue_access(wbr_pkg::REQ_READ,  wbr_pkg::SIZE_DWORD, 32'h0000_00FC, 32'hFFFF_FFFF);
    issue_access(wbr_pkg::REQ_READ,  wbr_pkg::SIZE_DWORD, 32'h0000_00FF, 32'h0);
    issue_access(wbr_pkg::REQ_WRITE, wbr_pkg::SIZE_DWORD, 32'h0000_0000, 32'hFFFF_FFFF);
    issue_access(wbr_pkg::REQ_READ,  wbr_pkg::SIZE_HALF,  32'h0000_0001, 32'h0);
    issue_access(wbr_pkg::REQ_READ,  wbr_pkg::SIZE_BYTE,  32'h0000_0000, 32'h0);
    issue_access(wbr_pkg::REQ_READ,  wbr_pkg::SIZE_DWORD, 32'hFFFF_FFFF, 32'h0);
    issue_access(wbr_pkg::REQ_WRITE, wbr_pkg::SIZE_DWORD, 32'hFFFF_FFFC, 32'h0);
    issue_access(wbr_pkg::REQ_WRITE, wbr_pkg::SIZE_DWORD, 32'h0000_0004, 32'h0);
    issue_access(wbr_pkg::REQ_READ,  wbr_pkg::SIZE_DWORD, 32'h0000_0002, 32'h0);
    issue_access(wbr_pkg::REQ_WRITE, wbr_pkg::SIZE_HALF,  32'h0000_0080, 32'h5A5A_C33C);
    issue_access(wbr_pkg::REQ_READ,  wbr_pkg::SIZE_DWORD, 32'h0000_007F, 32'h0);
    issue_access(wbr_pkg::REQ_READ,  wbr_pkg::SIZE_BYTE,  32'h0000_00FF, 32'h0);
    issue_access(wbr_pkg::REQ_WRITE, wbr_pkg::SIZE_BYTE,  32'h0000_00FF, 32'h0);
    issue_access(wbr_pkg::REQ_READ,  wbr_pkg::SIZE_HALF,  32'h0000_00FF, 32'h0);
    drain_results();

    chunk_base[0] = 32'hFFFF_FF00;
    chunk_base[1] = 32'hFFFF_FFFF;
    chunk_base[2] = $urandom;
    chunk_base[3] = 32'h0000_0000;
    chunk_base[4] = 32'h0000_0003;
    chunk_base[5] = $urandom;

    for (int c = 0; c < 6; c++) begin
      case (c / 2)
        0: begin
          src_gap_pct   <= 10;
          snk_stall_pct <= 84;
        end
        1: begin
          src_gap_pct   <= 84;
          snk_stall_pct <= 10;
        end
        default: begin
          src_gap_pct   <= 0;
          snk_stall_pct <= 0;
        end
      endcase
      write_base(chunk_base[c]);
      for (int n = 0; n < CHUNK_ACCESSES; n++) begin
        rq = $urandom_range(0, 1) ? wbr_pkg::REQ_WRITE : wbr_pkg::REQ_READ;
        sz = ($urandom_range(0, 15) == 0) ? SIZE_UNUSED : 2'($urandom_range(0, 2));
        issue_access(rq, sz, pick_address(chunk_base[c]), $urandom);
      end
      drain_results();
    end

    // Catch any stray result word after the last expected one
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
